>>> design/mies_pkg.sv
package mies_pkg;

   typedef struct packed {
      logic        req_type;
      logic [31:0] instr;
      logic [31:0] pc;
      logic [31:0] load_data;
   } req_type_t_type;

   typedef struct packed {
      logic        unimplemented;
      logic        addr_error;
      logic        branch_taken;
      logic [31:0] branch_target;
      logic        mem_valid;
      logic        mem_write;
      logic [31:0] mem_addr;
      logic [1:0]  mem_size;
      logic [31:0] store_data;
      logic        wb_valid;
      logic [4:0]  wb_reg;
      logic [31:0] wb_value;
   } rsp_type;

   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_BLEZ    = 6'h06;
   localparam logic [5:0] OP_BGTZ    = 6'h07;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_SLTI    = 6'h0A;
   localparam logic [5:0] OP_SLTIU   = 6'h0B;
   localparam logic [5:0] OP_LUI     = 6'h0F;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_LBU     = 6'h24;
   localparam logic [5:0] OP_LHU     = 6'h25;
   localparam logic [5:0] OP_SB      = 6'h28;
   localparam logic [5:0] OP_SH      = 6'h29;
   localparam logic [5:0] OP_SW      = 6'h2B;
   localparam logic [5:0] OP_LL      = 6'h30;
   localparam logic [5:0] OP_SC      = 6'h38;

   localparam logic [5:0] FN_SLL  = 6'h00;
   localparam logic [5:0] FN_SRL  = 6'h02;
   localparam logic [5:0] FN_SRA  = 6'h03;
   localparam logic [5:0] FN_SLLV = 6'h04;
   localparam logic [5:0] FN_SRLV = 6'h06;
   localparam logic [5:0] FN_SRAV = 6'h07;
   localparam logic [5:0] FN_JR   = 6'h08;
   localparam logic [5:0] FN_JALR = 6'h09;
   localparam logic [5:0] FN_MOVZ = 6'h0A;
   localparam logic [5:0] FN_MOVN = 6'h0B;
   localparam logic [5:0] FN_ADDU = 6'h21;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;

   localparam logic       REQ_EXEC = 1'b0;
   localparam logic       REQ_LOAD = 1'b1;

endpackage

>>> design/mies_ram.sv
module mies_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

>>> design/mips32_integer_execute_subset.sv
// MIPS32 integer execute unit (subset) with its own 32-entry register file.
// req channel: one request per instruction (req_type 0: instr + pc) or per
// returning load (req_type 1: load_data for the outstanding load).
// rsp channel: exactly one response per request, carrying branch decision,
// memory request and register write-back.
// Pipeline: request accepted -> register file read (two RAM copies, one
// per read port, registered read) -> execute and write back ->
// response register. One request per cycle sustained while rsp_ready is
// high. The execute stage forwards its own write to the read stage
// behind it, so back-to-back dependants see fresh data.
// Stall: when rsp_ready is low the response is held and the pipe freezes;
// req_ready drops only when both the response register and read stage
// are full.
// Reset: pipe empties, pending load clears. The RAM contents are not
// cleared; a 32-entry written-mask flop vector makes untouched registers
// read as zero.
module mips32_integer_execute_subset #(
   parameter int REG_COUNT = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  mies_pkg::req_type_t_type    req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output mies_pkg::rsp_type           rsp_data
);
   localparam int AW = $clog2(REG_COUNT);

   // stage 1: request in flight while RAM read happens
   logic                     s1_valid_ff, s1_valid_in;
   mies_pkg::req_type_t_type s1_req_ff;
   logic                     out_valid_ff, out_valid_in;
   mies_pkg::rsp_type        out_ff, res;
   logic [REG_COUNT-1:0]     written_ff, written_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic [AW-1:0]            pend_reg_ff, pend_reg_in;
   logic [1:0]               pend_kind_ff, pend_kind_in;

   logic adv;     // stage 1 moves into output register
   logic take;    // request accepted
   assign adv  = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || adv;
   assign take = req_valid && req_ready;

   logic [AW-1:0] ra_s, ra_t;
   assign ra_s = req_data.instr[21+AW-1:21];
   assign ra_t = req_data.instr[16+AW-1:16];

   logic          we;
   logic [AW-1:0] wa;
   logic [31:0]   wd;
   logic [31:0]   ram_s, ram_t;

   // read address held when stalled so RAM data stays valid
   logic [AW-1:0] rd_s, rd_t;
   assign rd_s = take ? ra_s : s1_req_ff.instr[21+AW-1:21];
   assign rd_t = take ? ra_t : s1_req_ff.instr[16+AW-1:16];

   mies_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_ram_s (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(rd_s), .rd_data(ram_s));
   mies_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_ram_t (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(rd_t), .rd_data(ram_t));

   // written mask is sampled alongside RAM read
   logic rs_ok_ff, rt_ok_ff;
   // bypass: a write in the cycle of the read is missed by the RAM
   logic byp_s_ff, byp_t_ff;
   logic [31:0] byp_d_ff;

   always_ff @(posedge clock) begin
      rs_ok_ff <= written_in[rd_s] && (rd_s != '0);
      rt_ok_ff <= written_in[rd_t] && (rd_t != '0);
      byp_s_ff <= we && (wa == rd_s);
      byp_t_ff <= we && (wa == rd_t);
      byp_d_ff <= wd;
   end

   logic [31:0] vs, vt;
   assign vs = !rs_ok_ff ? 32'd0 : (byp_s_ff ? byp_d_ff : ram_s);
   assign vt = !rt_ok_ff ? 32'd0 : (byp_t_ff ? byp_d_ff : ram_t);

   // execute
   logic [31:0] ins, pc, ld, simm, rel, addr, ldm;
   logic [5:0]  op, fn;
   logic [AW-1:0] rt, rd;
   logic [4:0]  sa;
   logic        wv, mem_acc, is_st, mis;
   logic [AW-1:0] wr;
   logic [31:0] wval;
   logic [1:0]  size;

   assign ins  = s1_req_ff.instr;
   assign pc   = s1_req_ff.pc;
   assign ld   = s1_req_ff.load_data;
   assign op   = ins[31:26];
   assign fn   = ins[5:0];
   assign rt   = ins[16+AW-1:16];
   assign rd   = ins[11+AW-1:11];
   assign sa   = ins[10:6];
   assign simm = {{16{ins[15]}}, ins[15:0]};
   assign rel  = pc + 32'd4 + {simm[29:0], 2'b00};
   assign addr = vs + simm;

   always_comb begin
      res = '0;
      wv = 1'b0; wr = '0; wval = '0;
      mem_acc = 1'b0; is_st = 1'b0; size = mies_pkg::SIZE_BYTE; mis = 1'b0;
      pend_valid_in = pend_valid_ff;
      pend_reg_in = pend_reg_ff;
      pend_kind_in = pend_kind_ff;
      ldm = ld;
      if (s1_req_ff.req_type == mies_pkg::REQ_LOAD) begin
         if (pend_valid_ff) begin
            case (pend_kind_ff)
               mies_pkg::SIZE_BYTE: ldm = {24'd0, ld[7:0]};
               mies_pkg::SIZE_HALF: ldm = {16'd0, ld[15:0]};
               default:             ldm = ld;
            endcase
            wv = 1'b1; wr = pend_reg_ff; wval = ldm;
            pend_valid_in = 1'b0;
         end
      end else begin
         case (op)
            mies_pkg::OP_SPECIAL: begin
               case (fn)
                  mies_pkg::FN_SLL: begin wv = 1'b1; wr = rd; wval = vt << sa; end
                  mies_pkg::FN_SRL: begin
                     if (ins[21]) res.unimplemented = 1'b1;
                     else begin wv = 1'b1; wr = rd; wval = vt >> sa; end
                  end
                  mies_pkg::FN_SRA: begin
                     wv = 1'b1; wr = rd; wval = $signed(vt) >>> sa;
                  end
                  mies_pkg::FN_SLLV: begin wv = 1'b1; wr = rd; wval = vt << vs[4:0]; end
                  mies_pkg::FN_SRLV: begin
                     if (ins[6]) res.unimplemented = 1'b1;
                     else begin wv = 1'b1; wr = rd; wval = vt >> vs[4:0]; end
                  end
                  mies_pkg::FN_SRAV: begin
                     wv = 1'b1; wr = rd; wval = $signed(vt) >>> vs[4:0];
                  end
                  mies_pkg::FN_JR: begin
                     res.branch_taken = 1'b1; res.branch_target = vs;
                  end
                  mies_pkg::FN_JALR: begin
                     res.branch_taken = 1'b1; res.branch_target = vs;
                     wv = 1'b1; wr = rd; wval = pc + 32'd8;
                  end
                  mies_pkg::FN_MOVZ: begin wv = (vt == '0); wr = rd; wval = vs; end
                  mies_pkg::FN_MOVN: begin wv = (vt != '0); wr = rd; wval = vs; end
                  mies_pkg::FN_ADDU: begin wv = 1'b1; wr = rd; wval = vs + vt; end
                  default: res.unimplemented = 1'b1;
               endcase
            end
            mies_pkg::OP_J, mies_pkg::OP_JAL: begin
               res.branch_taken = 1'b1;
               res.branch_target = {rel[31:28] & 4'hF, ins[25:0], 2'b00};
               res.branch_target[31:28] = (pc[31:28] + {3'd0, &pc[27:2]});
               if (op == mies_pkg::OP_JAL) begin
                  wv = 1'b1; wr = AW'(31); wval = pc + 32'd8;
               end
            end
            mies_pkg::OP_BEQ: if (vs == vt) begin
               res.branch_taken = 1'b1; res.branch_target = rel;
            end
            mies_pkg::OP_BNE: if (vs != vt) begin
               res.branch_taken = 1'b1; res.branch_target = rel;
            end
            mies_pkg::OP_BLEZ: if (vs == '0 || vs[31]) begin
               res.branch_taken = 1'b1; res.branch_target = rel;
            end
            mies_pkg::OP_BGTZ: if (vs != '0 && !vs[31]) begin
               res.branch_taken = 1'b1; res.branch_target = rel;
            end
            mies_pkg::OP_ADDI, mies_pkg::OP_ADDIU: begin
               wv = 1'b1; wr = rt; wval = addr;
            end
            mies_pkg::OP_SLTI: begin
               wv = 1'b1; wr = rt; wval = {31'd0, $signed(vs) < $signed(simm)};
            end
            mies_pkg::OP_SLTIU: begin
               wv = 1'b1; wr = rt; wval = {31'd0, vs < simm};
            end
            mies_pkg::OP_LUI: begin wv = 1'b1; wr = rt; wval = {ins[15:0], 16'd0}; end
            mies_pkg::OP_LW, mies_pkg::OP_LL: begin mem_acc = 1'b1; size = mies_pkg::SIZE_WORD; end
            mies_pkg::OP_LBU: begin mem_acc = 1'b1; size = mies_pkg::SIZE_BYTE; end
            mies_pkg::OP_LHU: begin mem_acc = 1'b1; size = mies_pkg::SIZE_HALF; end
            mies_pkg::OP_SB: begin mem_acc = 1'b1; is_st = 1'b1; size = mies_pkg::SIZE_BYTE; end
            mies_pkg::OP_SH: begin mem_acc = 1'b1; is_st = 1'b1; size = mies_pkg::SIZE_HALF; end
            mies_pkg::OP_SW, mies_pkg::OP_SC: begin
               mem_acc = 1'b1; is_st = 1'b1; size = mies_pkg::SIZE_WORD;
            end
            default: res.unimplemented = 1'b1;
         endcase
         if (mem_acc) begin
            mis = (size == mies_pkg::SIZE_WORD && addr[1:0] != 2'd0) ||
                  (size == mies_pkg::SIZE_HALF && addr[0]);
            res.mem_write = is_st;
            res.mem_addr  = addr;
            res.mem_size  = size;
            res.addr_error = mis;
            if (!mis) begin
               res.mem_valid = 1'b1;
               if (is_st) begin
                  res.store_data = vt;
                  if (op == mies_pkg::OP_SC) begin wv = 1'b1; wr = rt; wval = 32'd1; end
               end else begin
                  pend_valid_in = 1'b1; pend_reg_in = rt; pend_kind_in = size;
               end
            end
         end
      end
      if (wv && wr != '0) begin
         res.wb_valid = 1'b1; res.wb_reg = 5'(wr); res.wb_value = wval;
      end
   end

   assign we = adv && res.wb_valid;
   assign wa = res.wb_reg[AW-1:0];
   assign wd = res.wb_value;

   always_comb begin
      written_in = written_ff;
      if (we) written_in[wa] = 1'b1;
      s1_valid_in = take ? 1'b1 : (adv ? 1'b0 : s1_valid_ff);
      out_valid_in = adv ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         written_ff    <= '0;
         pend_valid_ff <= 1'b0;
         pend_reg_ff   <= '0;
         pend_kind_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         written_ff   <= written_in;
         if (adv) begin
            pend_valid_ff <= pend_valid_in;
            pend_reg_ff   <= pend_reg_in;
            pend_kind_ff  <= pend_kind_in;
         end
      end
   end

   // when stage 1 is stalled its operands would go stale on a later write;
   // stall only happens with no write, so captured RAM data stays right
   always_ff @(posedge clock) begin
      if (take) s1_req_ff <= req_data;
      if (adv)  out_ff    <= res;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
endmodule
